[rtl/core/dpw_pkg.sv]
// Package for the deferred progress watchdog.
// Holds field widths, event and phase codes, and the structs shared by the core modules.
// No dependencies.
`default_nettype none

package dpw_pkg;

  // Default parameter values.
  localparam int unsigned CountBitsDef  = 32;
  localparam int unsigned ThreadBitsDef = 16;

  // Fixed field widths.
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned TID_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEPTH_W    = 32;
  localparam int unsigned PERIOD_W   = 31;
  localparam int unsigned SRC_W      = 2;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned LIMIT_W    = PERIOD_W + 14;
  localparam int unsigned ELAPSED_W  = TIME_W + 1;
  localparam int unsigned PROD_W     = ELAPSED_W + TICK_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = PERIOD_W;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 8;

  // Milliseconds to 100 ns units.
  localparam int unsigned MsTo100ns = 10000;
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(156250);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENTER   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXIT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RESET   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd7;

  // Watch phases; PH_STOPPED only appears on the result.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_ARMED    = 2'd1;
  localparam logic [1:0] PH_REPORTED = 2'd2;
  localparam logic [1:0] PH_STOPPED  = 2'd3;

  // Reported events.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_TIMEOUT  = 2'd1;
  localparam logic [1:0] EV_RECOVERY = 2'd2;

  // Time sources.
  localparam logic [SRC_W-1:0] SRC_KERNEL = 2'd0;
  localparam logic [SRC_W-1:0] SRC_USER   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_BOTH   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd2;

  typedef struct packed {
    logic [SRC_W-1:0]   time_source;
    logic [TICK_W-1:0]  tick_length;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              incremental;
    logic [TID_W-1:0]  thread_id;
    logic [TIME_W-1:0] kernel_time;
    logic [TIME_W-1:0] user_time;
  } item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] phase;
    logic       suspended;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/dpw_cfg.sv]
// Configuration registers of the deferred progress watchdog.
// Keeps the time source, the tick length and the timeout limit in 100 ns units.
// Depends on dpw_pkg.
`default_nettype none

module dpw_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output dpw_pkg::cfg_t                       cfg_o
);
  import dpw_pkg::*;

  logic [SRC_W-1:0]   source_q;
  logic [TICK_W-1:0]  tick_q;
  logic [LIMIT_W-1:0] limit_q;

  // The period is stored already scaled, so the per-item compare needs no second multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= SRC_KERNEL;
      tick_q   <= TICK_RESET;
      limit_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD: limit_q  <= LIMIT_W'(cfg_data_i) * LIMIT_W'(MsTo100ns);
        CFG_SOURCE: source_q <= cfg_data_i[SRC_W-1:0];
        CFG_TICK:   tick_q   <= cfg_data_i[TICK_W-1:0];
        default:    ;
      endcase
    end
  end

  assign cfg_o.time_source = source_q;
  assign cfg_o.tick_length = tick_q;
  assign cfg_o.limit       = limit_q;

endmodule

`default_nettype wire

[rtl/core/dpw_core.sv]
// Watch state and per-request update of the deferred progress watchdog.
// Computes the result of one request combinationally and commits the state on step_i.
// Depends on dpw_pkg.
`default_nettype none

module dpw_core #(
  parameter int unsigned COUNT_BITS  = dpw_pkg::CountBitsDef,
  parameter int unsigned THREAD_BITS = dpw_pkg::ThreadBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  dpw_pkg::item_t      item_i,
  input  dpw_pkg::cfg_t       cfg_i,
  output dpw_pkg::res_t       res_o
);
  import dpw_pkg::*;

  logic                   running_q, running_d;
  logic [1:0]             phase_q, phase_d;
  logic [COUNT_BITS-1:0]  enter_q, enter_d, exit_q, exit_d;
  logic [COUNT_BITS-1:0]  snap_enter_q, snap_enter_d, snap_exit_q, snap_exit_d;
  logic [TIME_W-1:0]      snap_kernel_q, snap_kernel_d, snap_user_q, snap_user_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  logic                   owner_vld_q, owner_vld_d;
  logic [THREAD_BITS-1:0] owner_q, owner_d;
  logic [1:0]             last_q, last_d;
  logic [1:0]             ev;

  logic [THREAD_BITS-1:0] tid;
  logic                   in_section, moved;
  logic [TIME_W-1:0]      dk, du;
  logic [ELAPSED_W-1:0]   elapsed;
  logic [PROD_W-1:0]      product;
  logic                   expired;

  assign tid        = THREAD_BITS'(item_i.thread_id);
  assign in_section = enter_q != exit_q;
  assign moved      = (enter_q != snap_enter_q) || (exit_q != snap_exit_q);
  assign dk         = item_i.kernel_time - snap_kernel_q;
  assign du         = item_i.user_time - snap_user_q;

  always_comb begin
    case (cfg_i.time_source)
      SRC_KERNEL: elapsed = ELAPSED_W'(dk);
      SRC_USER:   elapsed = ELAPSED_W'(du);
      SRC_BOTH:   elapsed = ELAPSED_W'(dk) + ELAPSED_W'(du);
      default:    elapsed = '0;
    endcase
  end

  assign product = PROD_W'(elapsed) * PROD_W'(cfg_i.tick_length);
  assign expired = product >= PROD_W'(cfg_i.limit);

  always_comb begin
    running_d     = running_q;
    phase_d       = phase_q;
    enter_d       = enter_q;
    exit_d        = exit_q;
    snap_enter_d  = snap_enter_q;
    snap_exit_d   = snap_exit_q;
    snap_kernel_d = snap_kernel_q;
    snap_user_d   = snap_user_q;
    depth_d       = depth_q;
    owner_vld_d   = owner_vld_q;
    owner_d       = owner_q;
    last_d        = last_q;
    ev            = EV_NONE;

    unique case (item_i.kind)
      KIND_START, KIND_STOP: begin
        if (item_i.kind == KIND_START || running_q) begin
          if (item_i.kind == KIND_STOP && last_q == EV_TIMEOUT) begin
            ev     = EV_RECOVERY;
            last_d = EV_RECOVERY;
          end
          enter_d       = '0;
          exit_d        = '0;
          snap_enter_d  = '0;
          snap_exit_d   = '0;
          snap_kernel_d = '0;
          snap_user_d   = '0;
          phase_d       = PH_IDLE;
          owner_vld_d   = 1'b0;
          owner_d       = '0;
          running_d     = item_i.kind == KIND_START;
        end
      end
      KIND_ENTER: begin
        if (!owner_vld_q || owner_q != tid) begin
          phase_d     = PH_IDLE;
          owner_d     = tid;
          owner_vld_d = 1'b1;
        end
        enter_d = enter_q + 1'b1;
      end
      KIND_EXIT: exit_d = exit_q + 1'b1;
      KIND_SUSPEND: begin
        if (depth_q != '1) depth_d = depth_q + 1'b1;
      end
      KIND_RESUME: begin
        if (!item_i.incremental) depth_d = '0;
        else if (depth_q != '0) depth_d = depth_q - 1'b1;
      end
      KIND_RESET: begin
        enter_d = '0;
        exit_d  = '0;
        phase_d = PH_IDLE;
      end
      KIND_TICK: begin
        if (running_q && owner_vld_q) begin
          if (phase_q == PH_IDLE) begin
            if (depth_q == '0) begin
              if (last_q == EV_TIMEOUT && (moved || !in_section)) begin
                ev      = EV_RECOVERY;
                last_d  = EV_RECOVERY;
                phase_d = PH_REPORTED;
              end
              // Snapshot after the recovery check: it re-arms the watch.
              if (in_section) begin
                phase_d       = PH_ARMED;
                snap_enter_d  = enter_q;
                snap_exit_d   = exit_q;
                snap_kernel_d = item_i.kernel_time;
                snap_user_d   = item_i.user_time;
              end
            end
          end else if (phase_q == PH_ARMED) begin
            if (!in_section || depth_q != '0) begin
              phase_d = PH_IDLE;
            end else if (moved) begin
              snap_enter_d  = enter_q;
              snap_exit_d   = exit_q;
              snap_kernel_d = item_i.kernel_time;
              snap_user_d   = item_i.user_time;
            end else if (expired) begin
              ev      = EV_TIMEOUT;
              last_d  = EV_TIMEOUT;
              phase_d = PH_REPORTED;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      phase_q       <= PH_IDLE;
      enter_q       <= '0;
      exit_q        <= '0;
      snap_enter_q  <= '0;
      snap_exit_q   <= '0;
      snap_kernel_q <= '0;
      snap_user_q   <= '0;
      depth_q       <= '0;
      owner_vld_q   <= 1'b0;
      owner_q       <= '0;
      last_q        <= EV_NONE;
    end else if (step_i) begin
      running_q     <= running_d;
      phase_q       <= phase_d;
      enter_q       <= enter_d;
      exit_q        <= exit_d;
      snap_enter_q  <= snap_enter_d;
      snap_exit_q   <= snap_exit_d;
      snap_kernel_q <= snap_kernel_d;
      snap_user_q   <= snap_user_d;
      depth_q       <= depth_d;
      owner_vld_q   <= owner_vld_d;
      owner_q       <= owner_d;
      last_q        <= last_d;
    end
  end

  assign res_o.event_res = ev;
  assign res_o.phase     = running_d ? phase_d : PH_STOPPED;
  assign res_o.suspended = depth_d != '0;

endmodule

`default_nettype wire

[rtl/core/deferred_progress_watchdog_top.sv]
// Top level of the deferred progress watchdog.
// Instantiates dpw_cfg and dpw_core and holds the request and result registers.
// Depends on dpw_pkg, dpw_cfg and dpw_core.
//
// The block watches a code section that one thread enters and leaves. Requests arrive
// on the s_axis channel: tuser carries the request kind (start, stop, enter, exit,
// suspend, resume, reset, poll tick) and tdata carries the resume flag, the thread
// identity and, for a tick, the kernel and user run-time counters. Every request
// produces exactly one result on the m_axis channel: the reported event (none,
// timeout or recovery), the phase after the request and the suspended flag.
// A request is first captured in an input register; once the output register is free or
// being drained, its result is computed against the watch state and written to the
// output register, which drives m_axis_tvalid. While the receiver keeps up, one request
// is taken per cycle; the rate is set by the single pass through the elapsed-time
// multiply and limit compare. When the receiver stalls, the result waits in the output
// register, the pending request waits in the input register, and s_axis_tready drops
// only when both are full. Reset clears the watch state, both valid flags and the
// configuration (period zero, kernel time source, tick length 156250). Configuration
// writes on cfg_* take effect at the next clock edge; the user must see that they are
// only made while the block is idle, as the block itself does not enforce this.
`default_nettype none

module deferred_progress_watchdog_top #(
  parameter int unsigned COUNT_BITS  = dpw_pkg::CountBitsDef,
  parameter int unsigned THREAD_BITS = dpw_pkg::ThreadBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request channel.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] incremental, [16:1] thread_id, [48:17] kernel_time, [80:49] user_time.
  input  wire logic [dpw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] kind.
  input  wire logic [dpw_pkg::KIND_W-1:0]      s_axis_tuser,
  // Result channel.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] event_res, [3:2] phase, [4] suspended.
  output logic [dpw_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [dpw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dpw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dpw_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  item_vld_q, item_vld_d;
  logic  res_vld_q, res_vld_d;
  logic  advance, accept;

  // The held request moves on whenever the output register is free or being drained.
  assign advance       = item_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !item_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item_vld_d = accept || (item_vld_q && !advance);
  assign res_vld_d  = advance || (res_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind        <= s_axis_tuser;
      item_q.incremental <= s_axis_tdata[0];
      item_q.thread_id   <= s_axis_tdata[16:1];
      item_q.kernel_time <= s_axis_tdata[48:17];
      item_q.user_time   <= s_axis_tdata[80:49];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  dpw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dpw_core #(
    .COUNT_BITS  (COUNT_BITS),
    .THREAD_BITS (THREAD_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {3'b000, res_q.suspended, res_q.phase, res_q.event_res};

endmodule

`default_nettype wire

[rtl/core/dpw_checker.sv]
// Port-level checks for the deferred progress watchdog.
// Holds the checker module and the bind that attaches it to the top level.
// Depends on dpw_pkg and deferred_progress_watchdog_top.
`default_nettype none

module dpw_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [dpw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import dpw_pkg::*;

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // No result is shown while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A ready receiver never back-pressures the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("request stalled with ready receiver");

  // A timeout leaves the watch running in the reported phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == EV_TIMEOUT |-> m_axis_tdata[3:2] == PH_REPORTED)
    else $error("timeout without reported phase");

  // A recovery never lands in the idle phase, and no unknown event code appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 &&
      (m_axis_tdata[1:0] != EV_RECOVERY || m_axis_tdata[3:2] != PH_IDLE))
    else $error("bad event code or recovery in idle phase");

endmodule

bind deferred_progress_watchdog_top dpw_checker u_dpw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
